@@ rtl/ttip_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and character helpers for the text-to-integer parser.
// No dependencies; every other file of the block refers to this package.
package ttip_pkg;

	// Position of the parser within the current string.
	typedef enum logic [1:0] {
		PH_LEAD   = 2'd0,
		PH_POS0   = 2'd1,
		PH_ZERO   = 2'd2,
		PH_DIGITS = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_SIGN_ONLY = 3'd2,
		ST_BAD_DIGIT = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	localparam logic [1:0] BASE_BIN = 2'd0;
	localparam logic [1:0] BASE_OCT = 2'd1;
	localparam logic [1:0] BASE_DEC = 2'd2;
	localparam logic [1:0] BASE_HEX = 2'd3;

	localparam logic [1:0] MODE_STRICT      = 2'd0;
	localparam logic [1:0] MODE_STOP        = 2'd1;
	localparam logic [1:0] MODE_LTRIM_STOP  = 2'd2;
	localparam logic [1:0] MODE_TRIM_STRICT = 2'd3;

	localparam logic [1:0] WID_8  = 2'd0;
	localparam logic [1:0] WID_16 = 2'd1;
	localparam logic [1:0] WID_32 = 2'd2;
	localparam logic [1:0] WID_64 = 2'd3;

	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_MODE   = 2'd1;
	localparam logic [1:0] REG_SIGNED = 2'd2;
	localparam logic [1:0] REG_WIDTH  = 2'd3;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_VT      = 8'h0B;
	localparam logic [7:0] CH_FF      = 8'h0C;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_B = 8'h62;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_LOWER_X = 8'h78;

	// Digit value used to flag a character that is no digit in any base.
	localparam logic [4:0] DIGIT_NONE = 5'd16;

	typedef struct packed {
		logic [1:0] base;
		logic [1:0] mode;
		logic       signed_r;
		logic [1:0] width;
	} cfg_t;

	typedef struct packed {
		logic [7:0] character;
		logic       end_of_string;
		logic       empty_string;
	} item_t;

	typedef struct packed {
		logic [63:0] magnitude;
		logic        negative;
		status_t     status;
	} result_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
			(c == CH_VT) || (c == CH_FF) || (c == CH_CR);
	endfunction

	function automatic logic [4:0] char_to_digit(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = c - CH_ZERO;
			return v[4:0];
		end
		if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
			v = c - CH_LOWER_A + 8'd10;
			return v[4:0];
		end
		if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
			v = c - CH_UPPER_A + 8'd10;
			return v[4:0];
		end
		return DIGIT_NONE;
	endfunction

endpackage

@@ rtl/ttip_cfg_regs.sv @@
`timescale 1ns / 1ps
// APB-style configuration registers of the text-to-integer parser.
// Depends on ttip_pkg for the register indexes and the cfg_t struct.
module ttip_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output ttip_pkg::cfg_t   cfg
);

	ttip_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base     <= ttip_pkg::BASE_DEC;
			cfg_q.mode     <= ttip_pkg::MODE_STRICT;
			cfg_q.signed_r <= 1'b1;
			cfg_q.width    <= ttip_pkg::WID_32;
		end else if (wr_en) begin
			unique case (reg_idx)
				ttip_pkg::REG_BASE:   cfg_q.base     <= pwdata[1:0];
				ttip_pkg::REG_MODE:   cfg_q.mode     <= pwdata[1:0];
				ttip_pkg::REG_SIGNED: cfg_q.signed_r <= pwdata[0];
				ttip_pkg::REG_WIDTH:  cfg_q.width    <= pwdata[1:0];
				default:              cfg_q          <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ttip_pkg::REG_BASE:   prdata = {30'd0, cfg_q.base};
			ttip_pkg::REG_MODE:   prdata = {30'd0, cfg_q.mode};
			ttip_pkg::REG_SIGNED: prdata = {31'd0, cfg_q.signed_r};
			ttip_pkg::REG_WIDTH:  prdata = {30'd0, cfg_q.width};
			default:              prdata = 32'd0;
		endcase
	end

endmodule

@@ rtl/ttip_parse_core.sv @@
`timescale 1ns / 1ps
// Per-string parse state and the combinational character step, with the s2 result register.
// Depends on ttip_pkg for phase and status codes, character constants and structs.
module ttip_parse_core (
	input  logic                clk,
	input  logic                arst_n,
	input  ttip_pkg::cfg_t      cfg,
	input  logic                take,
	input  ttip_pkg::item_t     item,
	output logic                core_ready,
	input  logic                s3_ready,
	output logic                res_valid_s2,
	output ttip_pkg::result_t   res_s2
);

	ttip_pkg::phase_t  phase_q, phase_d;
	ttip_pkg::status_t status_q, status_d, res_status;
	logic [63:0]       mag_q, mag_d;
	logic              neg_q, neg_d;
	logic              stopped_q, stopped_d;
	logic              tss_q, tss_d;
	logic              content_q, content_d;
	logic              item_end;

	assign item_end   = item.end_of_string || item.empty_string;
	assign core_ready = !res_valid_s2 || s3_ready;

	always_comb begin
		logic [7:0]       c;
		logic             sp;
		logic             strict;
		logic             do_take;
		logic             do_bad;
		logic             do_digit;
		logic             act;
		ttip_pkg::phase_t take_ph;
		logic [4:0]       d;
		logic [4:0]       bval;
		logic [67:0]      prod;
		logic [67:0]      total;
		logic [63:0]      lim_u;
		logic [63:0]      lim;

		c        = item.character;
		sp       = ttip_pkg::is_space(c);
		strict   = (cfg.mode == ttip_pkg::MODE_STRICT) ||
			(cfg.mode == ttip_pkg::MODE_TRIM_STRICT);
		do_take  = 1'b0;
		do_bad   = 1'b0;
		do_digit = 1'b0;
		take_ph  = phase_q;

		phase_d   = phase_q;
		status_d  = status_q;
		mag_d     = mag_q;
		neg_d     = neg_q;
		stopped_d = stopped_q;
		tss_d     = tss_q;
		content_d = content_q;

		if (!item.empty_string) begin
			if (phase_q == ttip_pkg::PH_LEAD) begin
				if (!(cfg.mode[1] && sp)) begin
					content_d = 1'b1;
					phase_d   = ttip_pkg::PH_POS0;
					if (cfg.signed_r && (c == ttip_pkg::CH_PLUS || c == ttip_pkg::CH_MINUS)) begin
						neg_d = (c == ttip_pkg::CH_MINUS);
					end else begin
						do_take = 1'b1;
						take_ph = ttip_pkg::PH_POS0;
					end
				end
			end else if (cfg.mode == ttip_pkg::MODE_TRIM_STRICT && sp) begin
				tss_d = 1'b1;
			end else if (tss_q) begin
				// Whitespace held back inside the string acts as a bad digit; the
				// character after it can then no longer change anything.
				tss_d   = 1'b0;
				phase_d = ttip_pkg::PH_DIGITS;
				do_bad  = 1'b1;
			end else begin
				do_take = 1'b1;
			end
		end

		if (do_take) begin
			unique case (take_ph) inside
				ttip_pkg::PH_POS0: begin
					if (cfg.base == ttip_pkg::BASE_BIN && c == ttip_pkg::CH_LOWER_B) begin
						phase_d = ttip_pkg::PH_DIGITS;
					end else begin
						phase_d = (cfg.base == ttip_pkg::BASE_HEX && c == ttip_pkg::CH_ZERO) ?
							ttip_pkg::PH_ZERO : ttip_pkg::PH_DIGITS;
						do_digit = 1'b1;
					end
				end
				ttip_pkg::PH_ZERO: begin
					phase_d  = ttip_pkg::PH_DIGITS;
					do_digit = !(c == ttip_pkg::CH_LOWER_X || c == ttip_pkg::CH_UPPER_X);
				end
				ttip_pkg::PH_LEAD, ttip_pkg::PH_DIGITS: begin
					do_digit = 1'b1;
				end
				default: do_digit = 1'b1;
			endcase
		end

		d = do_bad ? ttip_pkg::DIGIT_NONE : ttip_pkg::char_to_digit(c);

		case (cfg.base)
			ttip_pkg::BASE_BIN: bval = 5'd2;
			ttip_pkg::BASE_OCT: bval = 5'd8;
			ttip_pkg::BASE_DEC: bval = 5'd10;
			default:            bval = 5'd16;
		endcase

		// Multiply by the base as shifts and adds, wide enough that it cannot wrap.
		case (cfg.base)
			ttip_pkg::BASE_BIN: prod = {3'd0, mag_q, 1'b0};
			ttip_pkg::BASE_OCT: prod = {1'b0, mag_q, 3'd0};
			ttip_pkg::BASE_DEC: prod = {1'b0, mag_q, 3'd0} + {3'd0, mag_q, 1'b0};
			default:            prod = {mag_q, 4'd0};
		endcase
		total = prod + {63'd0, d};

		case (cfg.width)
			ttip_pkg::WID_8:  lim_u = 64'h0000_0000_0000_00FF;
			ttip_pkg::WID_16: lim_u = 64'h0000_0000_0000_FFFF;
			ttip_pkg::WID_32: lim_u = 64'h0000_0000_FFFF_FFFF;
			default:          lim_u = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		// A negative value may reach one more than the positive signed limit.
		lim = cfg.signed_r ? ({1'b0, lim_u[63:1]} + {63'd0, neg_q}) : lim_u;

		act = (do_digit || do_bad) && (status_q == ttip_pkg::ST_OK) && !stopped_q;
		if (act) begin
			if (d >= bval) begin
				if (strict) begin
					status_d = ttip_pkg::ST_BAD_DIGIT;
				end else begin
					stopped_d = 1'b1;
				end
			end else if (total > {4'd0, lim}) begin
				status_d = ttip_pkg::ST_OVERFLOW;
			end else begin
				mag_d = total[63:0];
			end
		end

		if (!content_d) begin
			res_status = ttip_pkg::ST_EMPTY;
		end else if (phase_d == ttip_pkg::PH_POS0) begin
			res_status = ttip_pkg::ST_SIGN_ONLY;
		end else begin
			res_status = status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ttip_pkg::PH_LEAD;
			status_q  <= ttip_pkg::ST_OK;
			mag_q     <= 64'd0;
			neg_q     <= 1'b0;
			stopped_q <= 1'b0;
			tss_q     <= 1'b0;
			content_q <= 1'b0;
		end else if (take) begin
			if (item_end) begin
				phase_q   <= ttip_pkg::PH_LEAD;
				status_q  <= ttip_pkg::ST_OK;
				mag_q     <= 64'd0;
				neg_q     <= 1'b0;
				stopped_q <= 1'b0;
				tss_q     <= 1'b0;
				content_q <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				status_q  <= status_d;
				mag_q     <= mag_d;
				neg_q     <= neg_d;
				stopped_q <= stopped_d;
				tss_q     <= tss_d;
				content_q <= content_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (take && item_end) begin
			res_valid_s2 <= 1'b1;
		end else if (s3_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_end) begin
			res_s2.magnitude <= mag_d;
			res_s2.negative  <= neg_d;
			res_s2.status    <= res_status;
		end
	end

endmodule

@@ rtl/ttip_out_stage.sv @@
`timescale 1ns / 1ps
// Output register of the text-to-integer parser: applies the sign and zeroes failed results.
// Depends on ttip_pkg for the result_t struct and status codes.
module ttip_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid_s2,
	input  ttip_pkg::result_t   res_s2,
	output logic                s3_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [63:0]         parsed_value,
	output logic [2:0]          parse_status
);

	logic        load;
	logic [63:0] value;

	assign s3_ready = !out_valid || out_ready;
	assign load     = res_valid_s2 && s3_ready;

	always_comb begin
		if (res_s2.status != ttip_pkg::ST_OK) begin
			value = 64'd0;
		end else if (res_s2.negative) begin
			value = 64'd0 - res_s2.magnitude;
		end else begin
			value = res_s2.magnitude;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			parsed_value <= value;
			parse_status <= res_s2.status;
		end
	end

endmodule

@@ rtl/text_to_integer_parser_unit.sv @@
`timescale 1ns / 1ps
// Top level of the streaming text-to-integer parser.
// Depends on ttip_pkg, ttip_cfg_regs, ttip_parse_core and ttip_out_stage.

// The parser takes one ASCII character of a string per request and returns one
// result, a 64-bit value and a status code, for every request that ends a string
// (end_of_string or empty_string set). It accepts a new request in every cycle
// unless the pipeline stalls as below; the character step, the digit multiply-
// accumulate and the overflow compare in the parse core, is combinational. A
// request that ends its string is loaded into the input register, then into the
// parse state and the s2 result register, and then into the output register that
// applies the sign and raises out_valid. Requests keep flowing while a finished
// result waits on out_ready, until the two result slots are full. Base, parse
// mode, signedness and width are written over the APB-style port at byte
// addresses 0, 4, 8 and 12 and must only change while no string is in flight;
// reads return the current values.
module text_to_integer_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Character requests.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  character,
	input  logic        end_of_string,
	input  logic        empty_string,
	// Results.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] parsed_value,
	output logic [2:0]  parse_status
);

	ttip_pkg::cfg_t    cfg;
	ttip_pkg::item_t   item_s1;
	ttip_pkg::result_t res_s2;
	logic              valid_s1;
	logic              core_ready;
	logic              take;
	logic              res_valid_s2;
	logic              s3_ready;

	// The input register drains into the parse core whenever the core can take
	// a request; the core only stalls when both result slots are occupied.
	assign take     = valid_s1 && core_ready;
	assign in_ready = !valid_s1 || core_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.character     <= character;
			item_s1.end_of_string <= end_of_string;
			item_s1.empty_string  <= empty_string;
		end
	end

	ttip_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ttip_parse_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.take         (take),
		.item         (item_s1),
		.core_ready   (core_ready),
		.s3_ready     (s3_ready),
		.res_valid_s2 (res_valid_s2),
		.res_s2       (res_s2)
	);

	ttip_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid_s2 (res_valid_s2),
		.res_s2       (res_s2),
		.s3_ready     (s3_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.parsed_value (parsed_value),
		.parse_status (parse_status)
	);

`ifndef ASSERT_OFF
	// A request that ends a string always fills the s2 result slot.
	a_end_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		take && (item_s1.end_of_string || item_s1.empty_string) |=> res_valid_s2)
		else $error("string end did not produce a pending result");

	// Backpressure at the input only comes when the input register and the s2 result slot are both full.
	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && res_valid_s2)
		else $error("input stalled without a full pipeline");

	// A delivered status is always one of the defined codes.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> parse_status <= ttip_pkg::ST_OVERFLOW)
		else $error("undefined parse status delivered");

	// A failed parse never carries a value.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parse_status != ttip_pkg::ST_OK |-> parsed_value == 64'd0)
		else $error("failed parse delivered a nonzero value");
`endif

endmodule
